// ----- rtl/core/rgbg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbg_pkg
// Shared types and constants of the brightness-preserving rgb gain block.
// ----------------------------------------------------------------------------
package rgbg_pkg;

   localparam int GAIN_BITS    = 8;
   localparam int CSR_IDX_BITS = 2;

   // register indexes of the csr port
   localparam logic [CSR_IDX_BITS-1:0] CSR_GAIN_RED   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GAIN_GREEN = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GAIN_BLUE  = 2'd2;

   localparam logic [GAIN_BITS-1:0] GAIN_RESET = 8'd1;

   typedef struct packed {
      logic [GAIN_BITS-1:0] red;
      logic [GAIN_BITS-1:0] green;
      logic [GAIN_BITS-1:0] blue;
   } gains_type;

endpackage

// ----- rtl/core/rgbg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbg_req_if / rgbg_rsp_if
// Valid/ready pixel channels into and out of the rgb gain block.
// ----------------------------------------------------------------------------
interface rgbg_req_if #(
   parameter int CHANNEL_BITS = 8
);
   logic                    valid;
   logic                    ready;
   logic [CHANNEL_BITS-1:0] red_in;
   logic [CHANNEL_BITS-1:0] green_in;
   logic [CHANNEL_BITS-1:0] blue_in;

   modport source (output valid, output red_in, output green_in, output blue_in,
                   input ready);
   modport sink   (input valid, input red_in, input green_in, input blue_in,
                   output ready);
endinterface

interface rgbg_rsp_if #(
   parameter int CHANNEL_BITS = 8
);
   logic                    valid;
   logic                    ready;
   logic [CHANNEL_BITS-1:0] red_out;
   logic [CHANNEL_BITS-1:0] green_out;
   logic [CHANNEL_BITS-1:0] blue_out;

   modport source (output valid, output red_out, output green_out, output blue_out,
                   input ready);
   modport sink   (input valid, input red_out, input green_out, input blue_out,
                   output ready);
endinterface

// ----- rtl/core/rgb_gain_max_preserving.sv -----
`timescale 1ns / 1ps
// Pipeline: gain products and peak, then weighted maximum and dividends, then the quotient
//   bits, most significant first, in the stages of the pipelined restoring divider.
// Throughput: one pixel per cycle unless the response side stalls; every stage holds its transaction under stall.
// Reset clears all valid bits and sets the three gains to 1.
// ----------------------------------------------------------------------------
// rgb_gain_max_preserving
// Per-channel gain that rescales the weighted pixel back to its original peak.
// ----------------------------------------------------------------------------
module rgb_gain_max_preserving #(
   parameter int CHANNEL_BITS = 8
) (
   input  logic                                    clock,
   input  logic                                    reset,
   rgbg_req_if.sink                                req_chan,
   rgbg_rsp_if.source                              rsp_chan,
   input  logic                                    csr_we,
   input  logic [rgbg_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  logic [rgbg_pkg::GAIN_BITS-1:0]          csr_wdata
);
   import rgbg_pkg::*;

   localparam int REM_W = CHANNEL_BITS + GAIN_BITS;

   gains_type gains_ff, gains_in;

   logic [CHANNEL_BITS:0]                           st_valid;
   logic [CHANNEL_BITS:0]                           st_ready;
   logic [CHANNEL_BITS:0][2:0][REM_W-1:0]           st_rem;
   logic [CHANNEL_BITS:0][2:0][CHANNEL_BITS-1:0]    st_quo;
   logic [CHANNEL_BITS:0][REM_W-1:0]                st_div;
   logic [CHANNEL_BITS:0]                           st_zero;

   always_comb begin
      gains_in = gains_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_GAIN_RED:   gains_in.red   = csr_wdata;
            CSR_GAIN_GREEN: gains_in.green = csr_wdata;
            CSR_GAIN_BLUE:  gains_in.blue  = csr_wdata;
            default:        gains_in = gains_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff <= '{red: GAIN_RESET, green: GAIN_RESET, blue: GAIN_RESET};
      end else begin
         gains_ff <= gains_in;
      end
   end

   rgbg_weight #(
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_weight (
      .clock     (clock),
      .reset     (reset),
      .gains     (gains_ff),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_red    (req_chan.red_in),
      .in_green  (req_chan.green_in),
      .in_blue   (req_chan.blue_in),
      .out_valid (st_valid[0]),
      .out_ready (st_ready[0]),
      .out_rem   (st_rem[0]),
      .out_quo   (st_quo[0]),
      .out_div   (st_div[0]),
      .out_zero  (st_zero[0])
   );

   for (genvar k = 0; k < CHANNEL_BITS; k++) begin : g_div
      rgbg_div_stage #(
         .CHANNEL_BITS (CHANNEL_BITS)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (st_valid[k]),
         .in_ready  (st_ready[k]),
         .in_rem    (st_rem[k]),
         .in_quo    (st_quo[k]),
         .in_div    (st_div[k]),
         .in_zero   (st_zero[k]),
         .out_valid (st_valid[k+1]),
         .out_ready (st_ready[k+1]),
         .out_rem   (st_rem[k+1]),
         .out_quo   (st_quo[k+1]),
         .out_div   (st_div[k+1]),
         .out_zero  (st_zero[k+1])
      );
   end

   // quotient never exceeds the peak, so it always fits the channel width
   assign rsp_chan.valid                   = st_valid[CHANNEL_BITS];
   assign st_ready[CHANNEL_BITS]           = rsp_chan.ready;
   assign rsp_chan.red_out   = st_zero[CHANNEL_BITS] ? '0 : st_quo[CHANNEL_BITS][0];
   assign rsp_chan.green_out = st_zero[CHANNEL_BITS] ? '0 : st_quo[CHANNEL_BITS][1];
   assign rsp_chan.blue_out  = st_zero[CHANNEL_BITS] ? '0 : st_quo[CHANNEL_BITS][2];

`ifndef ASSERT_OFF
   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("response valid right after reset");
`endif

endmodule

// ----- rtl/core/rgbg_weight.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbg_weight
// Two pipeline stages: channel gain products and peak, then weighted maximum
// and the dividends weighted * peak that feed the divider.
// ----------------------------------------------------------------------------
module rgbg_weight #(
   parameter int CHANNEL_BITS = 8,
   localparam int REM_W = CHANNEL_BITS + rgbg_pkg::GAIN_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  rgbg_pkg::gains_type              gains,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [CHANNEL_BITS-1:0]          in_red,
   input  logic [CHANNEL_BITS-1:0]          in_green,
   input  logic [CHANNEL_BITS-1:0]          in_blue,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic [2:0][REM_W-1:0]            out_rem,
   output logic [2:0][CHANNEL_BITS-1:0]     out_quo,
   output logic [REM_W-1:0]                 out_div,
   output logic                             out_zero
);
   import rgbg_pkg::*;

   localparam int PROD_W = REM_W + CHANNEL_BITS;

   // stage a: weighted channels and peak
   logic                         a_valid_ff, a_valid_in;
   logic [2:0][REM_W-1:0]        a_w_ff, a_w_in;
   logic [CHANNEL_BITS-1:0]      a_peak_ff, a_peak_in;
   logic                         a_ready;

   // stage b: dividends, divisor and black flag
   logic                         b_valid_ff, b_valid_in;
   logic [2:0][PROD_W-1:0]       b_prod_ff, b_prod_in;
   logic [REM_W-1:0]             b_div_ff, b_div_in;
   logic                         b_zero_ff, b_zero_in;
   logic                         b_ready;

   logic [CHANNEL_BITS-1:0]      peak_rg;
   logic [REM_W-1:0]             wmax_rg;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   always_comb begin
      peak_rg   = (in_red > in_green) ? in_red : in_green;
      a_peak_in = (in_blue > peak_rg) ? in_blue : peak_rg;
      a_w_in[0] = REM_W'(in_red)   * REM_W'(gains.red);
      a_w_in[1] = REM_W'(in_green) * REM_W'(gains.green);
      a_w_in[2] = REM_W'(in_blue)  * REM_W'(gains.blue);
      a_valid_in = a_ready ? in_valid : a_valid_ff;
   end

   always_comb begin
      wmax_rg    = (a_w_ff[0] > a_w_ff[1]) ? a_w_ff[0] : a_w_ff[1];
      b_div_in   = (a_w_ff[2] > wmax_rg) ? a_w_ff[2] : wmax_rg;
      b_zero_in  = (b_div_in == '0);
      for (int c = 0; c < 3; c++) begin
         b_prod_in[c] = PROD_W'(a_w_ff[c]) * PROD_W'(a_peak_ff);
      end
      b_valid_in = b_ready ? a_valid_ff : b_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && a_ready) begin
         a_w_ff    <= a_w_in;
         a_peak_ff <= a_peak_in;
      end
      if (a_valid_ff && b_ready) begin
         b_prod_ff <= b_prod_in;
         b_div_ff  <= b_div_in;
         b_zero_ff <= b_zero_in;
      end
   end

   // weighted <= wmax and peak < 2^CHANNEL_BITS, so the upper part stays below wmax
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         out_rem[c] = b_prod_ff[c][PROD_W-1:CHANNEL_BITS];
         out_quo[c] = b_prod_ff[c][CHANNEL_BITS-1:0];
      end
   end

   assign out_valid = b_valid_ff;
   assign out_div   = b_div_ff;
   assign out_zero  = b_zero_ff;

`ifndef ASSERT_OFF
   a_zero_means_black: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && b_zero_ff |-> (b_prod_ff[0] == '0) && (b_prod_ff[1] == '0) &&
                                  (b_prod_ff[2] == '0))
      else $error("black flag set with nonzero dividend");

   a_stage_b_holds: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && !out_ready |=> b_valid_ff && $stable(b_div_ff))
      else $error("stalled transaction lost in stage b");
`endif

endmodule

// ----- rtl/core/rgbg_div_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbg_div_stage
// One restoring-division step for all three channels, one quotient bit per
// stage, with its own valid bit and backpressure.
// ----------------------------------------------------------------------------
module rgbg_div_stage #(
   parameter int CHANNEL_BITS = 8,
   localparam int REM_W = CHANNEL_BITS + rgbg_pkg::GAIN_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [2:0][REM_W-1:0]            in_rem,
   input  logic [2:0][CHANNEL_BITS-1:0]     in_quo,
   input  logic [REM_W-1:0]                 in_div,
   input  logic                             in_zero,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic [2:0][REM_W-1:0]            out_rem,
   output logic [2:0][CHANNEL_BITS-1:0]     out_quo,
   output logic [REM_W-1:0]                 out_div,
   output logic                             out_zero
);
   import rgbg_pkg::*;

   logic                             valid_ff, valid_in;
   logic [2:0][REM_W-1:0]            rem_ff, rem_in;
   logic [2:0][CHANNEL_BITS-1:0]     quo_ff, quo_in;
   logic [REM_W-1:0]                 div_ff;
   logic                             zero_ff;
   logic [2:0][REM_W:0]              trial;
   logic [2:0][REM_W:0]              diff;

   assign in_ready = !valid_ff || out_ready;

   // {rem, quo} shifts left; dividend bits leave quo at the top, quotient bits enter below
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         trial[c] = {in_rem[c], in_quo[c][CHANNEL_BITS-1]};
         diff[c]  = trial[c] - {1'b0, in_div};
         if (trial[c] >= {1'b0, in_div}) begin
            rem_in[c] = diff[c][REM_W-1:0];
            quo_in[c] = {in_quo[c][CHANNEL_BITS-2:0], 1'b1};
         end else begin
            rem_in[c] = trial[c][REM_W-1:0];
            quo_in[c] = {in_quo[c][CHANNEL_BITS-2:0], 1'b0};
         end
      end
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         div_ff  <= in_div;
         zero_ff <= in_zero;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_quo   = quo_ff;
   assign out_div   = div_ff;
   assign out_zero  = zero_ff;

`ifndef ASSERT_OFF
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !zero_ff |-> (rem_ff[0] < div_ff) && (rem_ff[1] < div_ff) &&
                               (rem_ff[2] < div_ff))
      else $error("partial remainder not below divisor");
`endif

endmodule
